// File: hdl/lsr_pkg.sv
// lsr_pkg: shared constants, types and codes for the lifo stack with reverse
// no dependencies; used by the interfaces, lsr_store, lsr_ctrl and the top level
package lsr_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned ActW      = 2;
  localparam int unsigned ErrW      = 2;

  typedef logic [DataWidth-1:0] data_t;
  typedef logic [AddrW-1:0]     addr_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [ActW-1:0]      act_t;

  localparam act_t ActPush    = 2'd0;
  localparam act_t ActPop     = 2'd1;
  localparam act_t ActReverse = 2'd2;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

// File: hdl/lsr_if.sv
// lsr_req_if and lsr_rsp_if: valid/ready channels for operation and result beats
// depends on lsr_pkg
interface lsr_req_if;
  logic              valid;
  logic              ready;
  lsr_pkg::act_t     action;
  lsr_pkg::data_t    push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface lsr_rsp_if;
  logic                        valid;
  logic                        ready;
  lsr_pkg::data_t              popped_value;
  lsr_pkg::data_t              top_value;
  logic                        top_valid;
  lsr_pkg::cnt_t               entry_count;
  logic                        is_empty;
  logic [lsr_pkg::ErrW-1:0]    error_code;

  modport source (output valid, output popped_value, output top_value, output top_valid,
                  output entry_count, output is_empty, output error_code, input ready);
  modport sink   (input valid, input popped_value, input top_value, input top_valid,
                  input entry_count, input is_empty, input error_code, output ready);
endinterface

// File: hdl/lifo_stack_with_reverse_unit.sv
// lifo_stack_with_reverse_unit: top level, bounded lifo stack with order reversal
// depends on lsr_pkg, lsr_if, lsr_store and lsr_ctrl
//
//   channel  dir  handshake          payload
//   in_req   in   valid / ready      action, push_value
//   out_rsp  out  valid / ready      popped_value, top_value, top_valid,
//                                    entry_count, is_empty, error_code
//
// one result beat per operation beat; the top word is cached in a register
// push, errors, no-op, pop of the last entry, short reversals: the result is loaded as the beat is taken
// pop or reverse with two or more entries: the result waits in ST_READ for the store's registered read
// reset clears pointers, count and direction; the store needs no clearing
// a stalled result holds in the output register; a new beat is taken in the
// cycle that result is drained
module lifo_stack_with_reverse_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsr_req_if.sink   in_req,
  lsr_rsp_if.source out_rsp
);

  lsr_pkg::mem_req_t mem_req;
  lsr_pkg::data_t    mem_rdata;

  lsr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (in_req),
    .rsp     (out_rsp),
    .mem_o   (mem_req),
    .rdata_i (mem_rdata)
  );

  lsr_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// File: hdl/lsr_store.sv
// lsr_store: ring store of stack entries, one write and one read port,
// read data registered; depends on lsr_pkg
module lsr_store (
  input  logic              clk_i,
  input  lsr_pkg::mem_req_t req_i,
  output lsr_pkg::data_t    rdata_o
);

  lsr_pkg::data_t mem_q [lsr_pkg::Depth];
  lsr_pkg::data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lsr_ctrl.sv
// lsr_ctrl: stack pointers, direction flag, cached top word, sequencer and result register
// depends on lsr_pkg and the lsr_req_if / lsr_rsp_if interfaces
module lsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  lsr_req_if.sink           req,
  lsr_rsp_if.source         rsp,
  output lsr_pkg::mem_req_t mem_o,
  input  lsr_pkg::data_t    rdata_i
);

  lsr_pkg::state_e state_q, state_d;
  lsr_pkg::addr_t  bottom_q, bottom_d;
  lsr_pkg::cnt_t   count_q, count_d;
  logic            dir_q, dir_d;
  lsr_pkg::data_t  top_q, top_d;
  lsr_pkg::data_t  popped_q, popped_d;

  logic            rsp_valid_q, rsp_valid_d;
  lsr_pkg::data_t  rsp_popped_q, rsp_popped_d;
  lsr_pkg::data_t  rsp_top_q, rsp_top_d;
  lsr_pkg::cnt_t   rsp_count_q, rsp_count_d;
  lsr_pkg::err_e   rsp_err_q, rsp_err_d;

  logic            accept;
  logic            go_read;
  logic            load;
  lsr_pkg::err_e   err;
  lsr_pkg::addr_t  cnt_lo;
  lsr_pkg::addr_t  slot_cnt;
  lsr_pkg::addr_t  slot_cnt_m1;
  lsr_pkg::addr_t  slot_cnt_m2;

  function automatic lsr_pkg::addr_t slot_of(lsr_pkg::addr_t bottom, logic dir,
                                             lsr_pkg::addr_t idx);
    lsr_pkg::addr_t s;
    if (dir) begin
      s = bottom - idx;
    end else begin
      s = bottom + idx;
    end
    return s;
  endfunction

  assign req.ready = (state_q == lsr_pkg::ST_IDLE) && (!rsp_valid_q || rsp.ready);
  assign accept    = req.valid && req.ready;

  // index arithmetic wraps at the ring size
  assign cnt_lo      = count_q[lsr_pkg::AddrW-1:0];
  assign slot_cnt    = slot_of(bottom_q, dir_q, cnt_lo);
  assign slot_cnt_m1 = slot_of(bottom_q, dir_q, cnt_lo - lsr_pkg::addr_t'(1));
  assign slot_cnt_m2 = slot_of(bottom_q, dir_q, cnt_lo - lsr_pkg::addr_t'(2));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsr_pkg::ST_IDLE: begin
        if (go_read) begin
          state_d = lsr_pkg::ST_READ;
        end
      end
      lsr_pkg::ST_READ: begin
        state_d = lsr_pkg::ST_IDLE;
      end
      default: state_d = lsr_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    bottom_d  = bottom_q;
    count_d   = count_q;
    dir_d     = dir_q;
    top_d     = top_q;
    popped_d  = popped_q;
    go_read   = 1'b0;
    load      = 1'b0;
    err       = lsr_pkg::ERR_NONE;
    mem_o     = '0;
    rsp_popped_d = rsp_popped_q;
    rsp_top_d    = rsp_top_q;
    rsp_count_d  = rsp_count_q;
    rsp_err_d    = rsp_err_q;

    unique case (state_q)
      lsr_pkg::ST_IDLE: begin
        if (accept) begin
          popped_d = '0;
          case (req.action)
            lsr_pkg::ActPush: begin
              if (count_q == lsr_pkg::cnt_t'(lsr_pkg::Depth)) begin
                err = lsr_pkg::ERR_OVERFLOW;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = slot_cnt;
                mem_o.wdata = req.push_value;
                count_d     = count_q + lsr_pkg::cnt_t'(1);
                top_d       = req.push_value;
              end
            end
            lsr_pkg::ActPop: begin
              if (count_q == '0) begin
                err = lsr_pkg::ERR_UNDERFLOW;
              end else begin
                popped_d = top_q;
                count_d  = count_q - lsr_pkg::cnt_t'(1);
                if (count_q == lsr_pkg::cnt_t'(1)) begin
                  top_d = '0;
                end else begin
                  // fetch the entry that becomes the new top
                  mem_o.re    = 1'b1;
                  mem_o.raddr = slot_cnt_m2;
                  go_read     = 1'b1;
                end
              end
            end
            lsr_pkg::ActReverse: begin
              dir_d = ~dir_q;
              if (count_q > lsr_pkg::cnt_t'(1)) begin
                // old bottom entry becomes the top
                bottom_d    = slot_cnt_m1;
                mem_o.re    = 1'b1;
                mem_o.raddr = bottom_q;
                go_read     = 1'b1;
              end
            end
            default: ;
          endcase
          if (!go_read) begin
            load         = 1'b1;
            rsp_popped_d = popped_d;
            rsp_top_d    = top_d;
            rsp_count_d  = count_d;
            rsp_err_d    = err;
          end
        end
      end
      lsr_pkg::ST_READ: begin
        top_d        = rdata_i;
        load         = 1'b1;
        rsp_popped_d = popped_q;
        rsp_top_d    = rdata_i;
        rsp_count_d  = count_q;
        rsp_err_d    = lsr_pkg::ERR_NONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsr_pkg::ST_IDLE;
      bottom_q    <= '0;
      count_q     <= '0;
      dir_q       <= 1'b0;
      top_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bottom_q    <= bottom_d;
      count_q     <= count_d;
      dir_q       <= dir_d;
      top_q       <= top_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    if (load) begin
      rsp_popped_q <= rsp_popped_d;
      rsp_top_q    <= rsp_top_d;
      rsp_count_q  <= rsp_count_d;
      rsp_err_q    <= rsp_err_d;
    end
  end

  assign rsp.valid        = rsp_valid_q;
  assign rsp.popped_value = rsp_popped_q;
  assign rsp.top_value    = rsp_top_q;
  assign rsp.top_valid    = (rsp_count_q != '0);
  assign rsp.entry_count  = rsp_count_q;
  assign rsp.is_empty     = (rsp_count_q == '0);
  assign rsp.error_code   = rsp_err_q;

endmodule

// File: sim/lifo_stack_with_reverse_unit_tb.sv
// lifo_stack_with_reverse_unit_tb: self-checking bench for the lifo stack with reverse
// a directed table, then biased random fill/drain bursts under three idle patterns
// depends on lsr_pkg, lsr_if and the lifo_stack_with_reverse_unit rtl
module lifo_stack_with_reverse_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam lsr_pkg::act_t ActUnused  = 2'd3;
  localparam int unsigned   StallLimit = 2000;
  localparam int unsigned   TailCycles = 8;
  localparam int unsigned   PhaseItems = 308;

  typedef struct packed {
    lsr_pkg::data_t popped;
    lsr_pkg::data_t top;
    logic           top_valid;
    lsr_pkg::cnt_t  count;
    logic           empty;
    lsr_pkg::err_e  err;
  } stack_rsp_t;

  typedef struct {
    lsr_pkg::act_t  act;
    lsr_pkg::data_t value;
    bit             typed;
    stack_rsp_t     status;
  } op_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lsr_req_if req_if ();
  lsr_rsp_if rsp_if ();

  lifo_stack_with_reverse_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state: ring store, bottom slot, count, direction
  lsr_pkg::data_t model_words [lsr_pkg::Depth];
  lsr_pkg::addr_t model_bottom = '0;
  lsr_pkg::cnt_t  model_held   = '0;
  logic           model_down   = 1'b0;

  stack_rsp_t  due_status_q [$];

  // typed expectation travels with the beat
  logic        op_typed;
  stack_rsp_t  op_status;

  int unsigned src_idle_pct  = 29;
  int unsigned sink_idle_pct = 61;
  int unsigned idle_run      = 0;
  int unsigned fail_count    = 0;
  int unsigned n_ops, n_push, n_pop, n_rev, n_unused, n_checked;
  int unsigned n_under, n_over, n_deep_rev;

  op_row_t     directed_ops [26];

  function automatic stack_rsp_t status_of(lsr_pkg::data_t popped, lsr_pkg::data_t top,
                                           int unsigned cnt, lsr_pkg::err_e err);
    stack_rsp_t s;
    s.popped    = popped;
    s.top       = top;
    s.top_valid = (cnt != 0);
    s.count     = lsr_pkg::cnt_t'(cnt);
    s.empty     = (cnt == 0);
    s.err       = err;
    return s;
  endfunction

  function automatic lsr_pkg::addr_t slot_at(lsr_pkg::cnt_t idx);
    lsr_pkg::addr_t k;
    k = lsr_pkg::addr_t'(idx);
    return model_down ? lsr_pkg::addr_t'(model_bottom - k)
                      : lsr_pkg::addr_t'(model_bottom + k);
  endfunction

  function automatic stack_rsp_t apply_stack_op(lsr_pkg::act_t act, lsr_pkg::data_t value);
    stack_rsp_t r;
    r     = '0;
    r.err = lsr_pkg::ERR_NONE;
    case (act)
      lsr_pkg::ActPush: begin
        if (model_held == lsr_pkg::cnt_t'(lsr_pkg::Depth)) begin
          r.err = lsr_pkg::ERR_OVERFLOW;
        end else begin
          model_words[slot_at(model_held)] = value;
          model_held = lsr_pkg::cnt_t'(model_held + 1'b1);
        end
      end
      lsr_pkg::ActPop: begin
        if (model_held == '0) begin
          r.err = lsr_pkg::ERR_UNDERFLOW;
        end else begin
          model_held = lsr_pkg::cnt_t'(model_held - 1'b1);
          r.popped   = model_words[slot_at(model_held)];
        end
      end
      lsr_pkg::ActReverse: begin
        // bottom jumps to the old top, growth direction flips
        if (model_held != '0) model_bottom = slot_at(lsr_pkg::cnt_t'(model_held - 1'b1));
        model_down = ~model_down;
      end
      default: begin
      end
    endcase
    if (model_held != '0) r.top = model_words[slot_at(lsr_pkg::cnt_t'(model_held - 1'b1))];
    r.top_valid = (model_held != '0);
    r.count     = model_held;
    r.empty     = (model_held == '0);
    return r;
  endfunction

  task automatic report_fail(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_status(stack_rsp_t exp);
    if (rsp_if.popped_value !== exp.popped)
      report_fail($sformatf("beat %0d popped_value %h, expected %h", n_checked,
                            rsp_if.popped_value, exp.popped));
    if (rsp_if.top_value !== exp.top)
      report_fail($sformatf("beat %0d top_value %h, expected %h", n_checked,
                            rsp_if.top_value, exp.top));
    if (rsp_if.top_valid !== exp.top_valid)
      report_fail($sformatf("beat %0d top_valid %b, expected %b", n_checked,
                            rsp_if.top_valid, exp.top_valid));
    if (rsp_if.entry_count !== exp.count)
      report_fail($sformatf("beat %0d entry_count %0d, expected %0d", n_checked,
                            rsp_if.entry_count, exp.count));
    if (rsp_if.is_empty !== exp.empty)
      report_fail($sformatf("beat %0d is_empty %b, expected %b", n_checked,
                            rsp_if.is_empty, exp.empty));
    if (rsp_if.error_code !== exp.err)
      report_fail($sformatf("beat %0d error_code %0d, expected %0d", n_checked,
                            rsp_if.error_code, exp.err));
  endtask

  // operation beats feed the predictor, result beats are checked in order
  always @(posedge clk_i) begin : monitor
    stack_rsp_t pred;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        n_ops++;
        case (req_if.action)
          lsr_pkg::ActPush:    n_push++;
          lsr_pkg::ActPop:     n_pop++;
          lsr_pkg::ActReverse: begin
            n_rev++;
            if (model_held >= 2) n_deep_rev++;
          end
          default:             n_unused++;
        endcase
        pred = apply_stack_op(req_if.action, req_if.push_value);
        if (pred.err == lsr_pkg::ERR_UNDERFLOW) n_under++;
        if (pred.err == lsr_pkg::ERR_OVERFLOW)  n_over++;
        due_status_q = {due_status_q, (op_typed ? op_status : pred)};
      end
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        if (due_status_q.size() == 0) begin
          report_fail($sformatf("result beat %0d with nothing expected", n_checked));
        end else begin
          check_status(due_status_q.pop_front());
        end
        n_checked++;
      end
      idle_run <= moved ? 0 : idle_run + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (idle_run < StallLimit);
    $display("watchdog: no beat moved for %0d cycles", StallLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin : sink_ready
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= rst_ni && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_op(lsr_pkg::act_t act, lsr_pkg::data_t value, bit typed,
                         stack_rsp_t status);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.push_value <= value;
    op_typed          <= typed;
    op_status         <= status;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // bursts lean toward filling, draining or mixing so full and empty recur
  task automatic run_random(int unsigned count);
    int unsigned    done;
    int unsigned    burst_left;
    int unsigned    mode;
    int unsigned    pick;
    int unsigned    push_cut;
    int unsigned    pop_cut;
    lsr_pkg::act_t  act;
    lsr_pkg::data_t value;
    done       = 0;
    burst_left = 0;
    mode       = 0;
    while (done < count) begin
      if (burst_left == 0) begin
        mode       = $urandom_range(2);
        burst_left = $urandom_range(12, 40);
      end
      burst_left--;
      case (mode)
        0:       begin push_cut = 70; pop_cut = 85; end
        1:       begin push_cut = 20; pop_cut = 85; end
        default: begin push_cut = 42; pop_cut = 84; end
      endcase
      pick = $urandom_range(99);
      if (pick < push_cut)     act = lsr_pkg::ActPush;
      else if (pick < pop_cut) act = lsr_pkg::ActPop;
      else if (pick < 97)      act = lsr_pkg::ActReverse;
      else                     act = ActUnused;
      case ($urandom_range(15))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom();
      endcase
      send_op(act, value, 1'b0, '0);
      done++;
    end
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.action     <= lsr_pkg::ActPush;
    req_if.push_value <= '0;
    op_typed          <= 1'b0;
    op_status         <= '0;
    {n_ops, n_push, n_pop, n_rev, n_unused, n_checked} = '0;
    {n_under, n_over, n_deep_rev} = '0;

    directed_ops = '{
      '{lsr_pkg::ActPop,     32'h0000_0000, 1'b1,
        status_of('0, '0, 0, lsr_pkg::ERR_UNDERFLOW)},
      '{lsr_pkg::ActReverse, 32'h0000_0000, 1'b1, status_of('0, '0, 0, lsr_pkg::ERR_NONE)},
      '{ActUnused,           32'hFFFF_FFFF, 1'b1, status_of('0, '0, 0, lsr_pkg::ERR_NONE)},
      '{lsr_pkg::ActPush,    32'h0000_0000, 1'b1, status_of('0, '0, 1, lsr_pkg::ERR_NONE)},
      '{lsr_pkg::ActReverse, 32'h0000_0000, 1'b0, '0},
      '{lsr_pkg::ActPop,     32'h0000_0000, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'hFFFF_FFFF, 1'b1,
        status_of('0, 32'hFFFF_FFFF, 1, lsr_pkg::ERR_NONE)},
      '{lsr_pkg::ActPush,    32'h8000_0000, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'h0000_0001, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'h5555_5555, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'hAAAA_AAAA, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'h1234_5678, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'h0F0F_0F0F, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'hF0F0_F0F0, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'h7FFF_FFFF, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'h0000_FFFF, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'hFFFF_0000, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'hCAFE_F00D, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'h0BAD_C0DE, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'h1357_9BDF, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'h2468_ACE0, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'hFEDC_BA98, 1'b0, '0},
      '{lsr_pkg::ActPush,    32'hDEAD_BEEF, 1'b1,
        status_of('0, 32'hFEDC_BA98, lsr_pkg::Depth, lsr_pkg::ERR_OVERFLOW)},
      '{lsr_pkg::ActReverse, 32'h0000_0000, 1'b0, '0},
      '{lsr_pkg::ActPop,     32'h0000_0000, 1'b0, '0},
      '{ActUnused,           32'h0000_0000, 1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ops[i])
      send_op(directed_ops[i].act, directed_ops[i].value, directed_ops[i].typed,
              directed_ops[i].status);

    run_random(PhaseItems);
    src_idle_pct  <= 61;
    sink_idle_pct <= 29;
    run_random(PhaseItems);
    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    run_random(PhaseItems);
    req_if.valid <= 1'b0;

    while (due_status_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (due_status_q.size() != 0)
      report_fail($sformatf("%0d results never arrived", due_status_q.size()));

    $display("ran %0d operations (%0d push, %0d pop, %0d reverse, %0d unused code)",
             n_ops, n_push, n_pop, n_rev, n_unused);
    $display("checked %0d result beats; %0d underflows, %0d overflows, %0d deep reversals",
             n_checked, n_under, n_over, n_deep_rev);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: lifo_stack_with_reverse_unit.f
hdl/lsr_pkg.sv
hdl/lsr_if.sv
hdl/lsr_store.sv
hdl/lsr_ctrl.sv
hdl/lifo_stack_with_reverse_unit.sv
sim/lifo_stack_with_reverse_unit_tb.sv
